// File: hdl/lfu_pkg.sv
// Package for the least-frequently-used cache table.
// Holds sizes, the item and entry types and the controller states; no dependencies.
package lfu_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ADDR_W     = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W      = 5;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [31:0]           ALL_ONES  = 32'hFFFF_FFFF;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] lookup_key;
    logic signed [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               accepted;
    logic               evicted;
  } rsp_t;

  typedef struct packed {
    logic [31:0]           key;
    logic [31:0]           value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// File: hdl/lfu_req_if.sv
// Request channel of the cache table: valid/ready handshake carrying one req_t item.
// Depends on lfu_pkg.
interface lfu_req_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lfu_rsp_if.sv
// Response channel of the cache table: valid/ready handshake carrying one rsp_t item.
// Depends on lfu_pkg.
interface lfu_rsp_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lfu_cache_table.sv
// Top level of the least-frequently-used key/value cache table.
// Depends on lfu_pkg, lfu_req_if and lfu_rsp_if.
//
// Usage:
//   req_i carries one item per lookup or store (opcode, lookup_key, store_value).
//   rsp_o returns exactly one item per request (hit, read_value, accepted, evicted).
//   cfg_we_i/cfg_wdata_i write the capacity register; write it only while idle.
//   Values above ENTRIES act as ENTRIES; zero refuses every store.
// Timing:
//   One item is processed at a time. After acceptance the controller walks all
//   ENTRIES table rows through the single read port of the entry memory, one row
//   per cycle, then commits in ST_DONE once the response register is empty or
//   being taken. A new item is accepted only back in idle, after that commit.
// Reset:
//   All valid bits clear and capacity returns to ENTRIES; no clearing pass is needed
//   since keys, values and counts are only read for valid rows.
// Stall:
//   The response waits in an output register. The next item is accepted and scanned
//   while it waits; its commit holds until the earlier response has been taken.
module lfu_cache_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata_i,
  lfu_req_if.sink                   req_i,
  lfu_rsp_if.source                 rsp_o
);
  import lfu_pkg::*;

  // Entry memory: key, value and use count per row, one read and one write port.
  entry_t mem_q [ENTRIES];
  entry_t rd_q;

  // Valid bits and recency ranks live in flip-flops so that aging is parallel.
  logic [ENTRIES-1:0] vld_q;
  logic [IDX_W-1:0]   rank_q [ENTRIES];
  logic [IDX_W-1:0]   rd_rank_q;

  logic [CAP_W-1:0]   cap_q;
  state_e             state_q, state_d;
  req_t               req_q;

  logic [ADDR_W-1:0]  scan_addr_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;

  // Scan results.
  logic                  match_q, free_q, vic_q;
  logic [IDX_W-1:0]      match_idx_q, free_idx_q, vic_idx_q;
  logic [IDX_W-1:0]      match_rank_q, vic_rank_q;
  logic [COUNT_BITS-1:0] match_cnt_q, vic_cnt_q;
  logic [31:0]           match_val_q;

  rsp_t rsp_q;
  rsp_t rsp_d;
  logic rsp_vld_q;

  logic in_ready;
  logic commit;
  logic scan_last;
  logic [ADDR_W-1:0] nvalid;
  logic [ADDR_W-1:0] cap_eff;

  // Commit decisions.
  logic                  is_store;
  logic                  touch_match;
  logic                  do_insert;
  logic                  do_evict;
  logic [31:0]           upd_val;
  logic [COUNT_BITS-1:0] cnt_bump;

  always_comb begin
    nvalid = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      nvalid = nvalid + ADDR_W'(vld_q[i]);
    end
  end

  assign cap_eff = (ADDR_W'(cap_q) > ADDR_W'(ENTRIES)) ? ADDR_W'(ENTRIES)
                                                       : ADDR_W'(cap_q);
  assign scan_last = rd_vld_q && (rd_idx_q == IDX_W'(ENTRIES - 1));

  // A hit touches the matching row; a store of a new key fills a free row while
  // the table is below capacity, else the scanned victim; zero capacity bars stores.
  assign is_store    = (req_q.opcode == OP_STORE);
  assign touch_match = match_q && (!is_store || cap_eff != '0);
  assign do_insert   = is_store && cap_eff != '0 && !match_q && nvalid < cap_eff && free_q;
  assign do_evict    = is_store && cap_eff != '0 && !match_q &&
                       !(nvalid < cap_eff && free_q) && vic_q;
  assign upd_val     = is_store ? req_q.store_value : match_val_q;
  assign cnt_bump    = (match_cnt_q == COUNT_MAX) ? COUNT_MAX : match_cnt_q + 1'b1;

  always_comb begin
    rsp_d.hit        = match_q;
    rsp_d.read_value = (!is_store && match_q) ? match_val_q : ALL_ONES;
    rsp_d.accepted   = !is_store || cap_eff != '0;
    rsp_d.evicted    = do_evict;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: ;
      ST_DONE: commit = !rsp_vld_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= CAP_W'(ENTRIES);
      vld_q     <= '0;
      rsp_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      rd_vld_q <= (state_q == ST_SCAN) && (scan_addr_q < ADDR_W'(ENTRIES));
      if (commit) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      if (commit && do_insert) begin
        vld_q[free_idx_q] <= 1'b1;
      end
    end
  end

  // Memory read side and the scan evaluation, one row per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && in_ready) begin
      req_q       <= req_i.data;
      scan_addr_q <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
    end
    if (state_q == ST_SCAN && scan_addr_q < ADDR_W'(ENTRIES)) begin
      rd_q        <= mem_q[scan_addr_q[IDX_W-1:0]];
      rd_rank_q   <= rank_q[scan_addr_q[IDX_W-1:0]];
      rd_idx_q    <= scan_addr_q[IDX_W-1:0];
      scan_addr_q <= scan_addr_q + 1'b1;
    end
    if (rd_vld_q) begin
      if (vld_q[rd_idx_q]) begin
        if (!match_q && rd_q.key == req_q.lookup_key) begin
          match_q      <= 1'b1;
          match_idx_q  <= rd_idx_q;
          match_rank_q <= rd_rank_q;
          match_cnt_q  <= rd_q.count;
          match_val_q  <= rd_q.value;
        end
        // Lowest count loses; on a tie the least recently touched row loses.
        if (!vic_q || rd_q.count < vic_cnt_q ||
            (rd_q.count == vic_cnt_q && rd_rank_q > vic_rank_q)) begin
          vic_q      <= 1'b1;
          vic_idx_q  <= rd_idx_q;
          vic_cnt_q  <= rd_q.count;
          vic_rank_q <= rd_rank_q;
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // Commit: write back the touched row, age the recency ranks, fill the response.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q <= rsp_d;
      if (touch_match) begin
        mem_q[match_idx_q] <= '{key: req_q.lookup_key, value: upd_val, count: cnt_bump};
        for (int i = 0; i < ENTRIES; i++) begin
          if (vld_q[i] && IDX_W'(i) != match_idx_q && rank_q[i] < match_rank_q)
            rank_q[i] <= rank_q[i] + 1'b1;
        end
        rank_q[match_idx_q] <= '0;
      end else if (do_insert) begin
        mem_q[free_idx_q] <= '{key: req_q.lookup_key, value: req_q.store_value,
                               count: COUNT_BITS'(1)};
        for (int i = 0; i < ENTRIES; i++) begin
          if (vld_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
        end
        rank_q[free_idx_q] <= '0;
      end else if (do_evict) begin
        mem_q[vic_idx_q] <= '{key: req_q.lookup_key, value: req_q.store_value,
                              count: COUNT_BITS'(1)};
        for (int i = 0; i < ENTRIES; i++) begin
          if (vld_q[i] && IDX_W'(i) != vic_idx_q && rank_q[i] < vic_rank_q)
            rank_q[i] <= rank_q[i] + 1'b1;
        end
        rank_q[vic_idx_q] <= '0;
      end
    end
  end

  // The number of valid rows never shrinks.
  a_valid_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(vld_q) >= $countones($past(vld_q)))
    else $error("valid row count decreased");

  // A commit always leaves a response waiting.
  a_commit_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_vld_q)
    else $error("commit did not produce a response");

  // Outside idle the scan address never exceeds ENTRIES, one past the last row.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_addr_q <= ADDR_W'(ENTRIES) || state_q == ST_IDLE)
    else $error("scan address out of range");

  // Leaving the final state always goes with a commit.
  a_done_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |-> commit)
    else $error("left final state without commit");

endmodule
